FILE: hw/rtl/mfc_pkg.sv
// Package for the frame checksum block: mode codes, register indexes, constants and types.
package mfc_pkg;

    // Check mode codes; codes above the reflected CRC act as the reflected CRC.
    localparam logic [2:0] MODE_SUM8      = 3'd0;
    localparam logic [2:0] MODE_SUM16     = 3'd1;
    localparam logic [2:0] MODE_XOR8      = 3'd2;
    localparam logic [2:0] MODE_CRC_CCITT = 3'd3;
    localparam logic [2:0] MODE_CRC_REFL  = 3'd4;

    // Finish codes for the sum and XOR modes; the spare code applies no finish.
    localparam logic [1:0] FINISH_NONE = 2'd0;
    localparam logic [1:0] FINISH_ONES = 2'd1;
    localparam logic [1:0] FINISH_TWOS = 2'd2;

    // Configuration register indexes.
    localparam logic [7:0] REG_CHECK_MODE  = 8'd0;
    localparam logic [7:0] REG_INIT_VALUE  = 8'd1;
    localparam logic [7:0] REG_COMPLEMENT  = 8'd2;
    localparam logic [7:0] REG_SWAP_RESULT = 8'd3;

    // Register reset values.
    localparam logic [2:0]  RESET_CHECK_MODE  = MODE_CRC_REFL;
    localparam logic [15:0] RESET_INIT_VALUE  = 16'hFFFF;
    localparam logic [1:0]  RESET_COMPLEMENT  = FINISH_NONE;
    localparam logic        RESET_SWAP_RESULT = 1'b1;

    // Polynomials.
    localparam logic [15:0] POLY_CCITT = 16'h1021;
    localparam logic [15:0] POLY_REFL  = 16'hA001;

    // Configuration as seen by the datapath.
    typedef struct packed {
        logic [2:0]  check_mode;
        logic [15:0] init_value;
        logic [1:0]  complement_mode;
        logic        swap_result;
    } cfg_t;

endpackage

FILE: hw/rtl/mfc_update.sv
// Per-byte accumulator update for all check modes.
module mfc_update (
    input  mfc_pkg::cfg_t cfg,
    input  logic [15:0]   acc_in,
    input  logic [7:0]    data_byte,
    output logic [15:0]   acc_out
);

    // CRC-CCITT, MSB first: shift, then fold the feedback bit into the polynomial.
    function automatic logic [15:0] ccitt_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        logic        fb;
        a = acc;
        for (int i = 7; i >= 0; i--) begin
            fb = a[15] ^ b[i];
            a  = {a[14:0], 1'b0} ^ (fb ? mfc_pkg::POLY_CCITT : 16'h0000);
        end
        return a;
    endfunction

    // Reflected CRC-16: XOR the byte into the low end, then eight right shifts.
    function automatic logic [15:0] refl_byte(input logic [15:0] acc, input logic [7:0] b);
        logic [15:0] a;
        a = acc ^ {8'h00, b};
        for (int i = 0; i < 8; i++) begin
            a = {1'b0, a[15:1]} ^ (a[0] ? mfc_pkg::POLY_REFL : 16'h0000);
        end
        return a;
    endfunction

    // Mode decoder; 8-bit modes keep only the low byte.
    always_comb begin
        unique case (cfg.check_mode)
            mfc_pkg::MODE_SUM8:      acc_out = {8'h00, acc_in[7:0] + data_byte};
            mfc_pkg::MODE_SUM16:     acc_out = acc_in + {8'h00, data_byte};
            mfc_pkg::MODE_XOR8:      acc_out = {8'h00, acc_in[7:0] ^ data_byte};
            mfc_pkg::MODE_CRC_CCITT: acc_out = ccitt_byte(acc_in, data_byte);
            default:                 acc_out = refl_byte(acc_in, data_byte);
        endcase
    end

endmodule

FILE: hw/rtl/mfc_finish.sv
// End-of-frame finish: complement for sums and LRC, byte swap for the reflected CRC.
module mfc_finish (
    input  mfc_pkg::cfg_t cfg,
    input  logic [15:0]   acc,
    output logic [15:0]   result
);

    logic [15:0] finished;

    // Optional one's or two's complement over the full word.
    always_comb begin
        case (cfg.complement_mode)
            mfc_pkg::FINISH_ONES: finished = ~acc;
            mfc_pkg::FINISH_TWOS: finished = ~acc + 16'd1;
            default:              finished = acc;
        endcase
    end

    // Select the finished form for the current mode.
    always_comb begin
        unique case (cfg.check_mode) inside
            mfc_pkg::MODE_SUM8,
            mfc_pkg::MODE_XOR8:      result = {8'h00, finished[7:0]};
            mfc_pkg::MODE_SUM16:     result = finished;
            mfc_pkg::MODE_CRC_CCITT: result = acc;
            default:                 result = cfg.swap_result ? {acc[7:0], acc[15:8]} : acc;
        endcase
    end

endmodule

FILE: hw/rtl/multi_mode_frame_checksum_top.sv
// Top level of the multi-mode frame checksum: input register, update, finish, result register.
//
//  channel  | direction | handshake           | payload
//  s_       | in        | s_valid / s_ready   | s_data_byte[7:0], s_frame_end
//  m_       | out       | m_valid / m_ready   | m_checksum_value[15:0]
//  cfg_     | in        | cfg_valid/cfg_ready | cfg_index[7:0], cfg_data[15:0]
//
// One byte is accepted per cycle unless a frame-end byte waits in the input register for room
// in the result register. An accepted byte is processed from the input register, and a
// frame-end byte leaving it writes its checksum into the result register. The
// accumulator byte update is combinational, with the eight CRC bit steps between the registers.
// Reset is synchronous and active low; it clears the valid flags, accumulator and frame state.
// A stalled result holds back only a frame-end byte and the input behind it.
module multi_mode_frame_checksum_top (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [7:0]  s_data_byte,
    input  logic        s_frame_end,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_checksum_value,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [7:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    mfc_pkg::cfg_t cfg_reg;
    logic          st_valid_reg;
    logic [7:0]    st_byte_reg;
    logic          st_end_reg;
    logic [15:0]   running_check_reg;
    logic          inside_frame_reg;
    logic          out_valid_reg;
    logic [15:0]   out_value_reg;

    logic          s_fire;
    logic          st_fire;
    logic [15:0]   acc_start;
    logic [15:0]   acc_updated;
    logic [15:0]   result;

    // Configuration writes are always taken; unknown indexes are dropped.
    assign cfg_ready = 1'b1;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.check_mode      <= mfc_pkg::RESET_CHECK_MODE;
            cfg_reg.init_value      <= mfc_pkg::RESET_INIT_VALUE;
            cfg_reg.complement_mode <= mfc_pkg::RESET_COMPLEMENT;
            cfg_reg.swap_result     <= mfc_pkg::RESET_SWAP_RESULT;
        end else if (cfg_valid) begin
            unique case (cfg_index)
                mfc_pkg::REG_CHECK_MODE:  cfg_reg.check_mode      <= cfg_data[2:0];
                mfc_pkg::REG_INIT_VALUE:  cfg_reg.init_value      <= cfg_data;
                mfc_pkg::REG_COMPLEMENT:  cfg_reg.complement_mode <= cfg_data[1:0];
                mfc_pkg::REG_SWAP_RESULT: cfg_reg.swap_result     <= cfg_data[0];
                default: ;
            endcase
        end
    end

    // Stage control: a frame-end byte waits until the result register has room.
    assign st_fire = st_valid_reg && (!st_end_reg || !out_valid_reg || m_ready);
    assign s_ready = !st_valid_reg || st_fire;
    assign s_fire  = s_valid && s_ready;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            st_valid_reg <= 1'b0;
        end else begin
            st_valid_reg <= s_fire || (st_valid_reg && !st_fire);
        end
    end

    always_ff @(posedge aclk) begin
        if (s_fire) begin
            st_byte_reg <= s_data_byte;
            st_end_reg  <= s_frame_end;
        end
    end

    // The first byte of a frame starts from the configured initial value.
    assign acc_start = inside_frame_reg ? running_check_reg : cfg_reg.init_value;

    mfc_update u_update (
        .cfg       (cfg_reg),
        .acc_in    (acc_start),
        .data_byte (st_byte_reg),
        .acc_out   (acc_updated)
    );

    mfc_finish u_finish (
        .cfg    (cfg_reg),
        .acc    (acc_updated),
        .result (result)
    );

    // Running accumulator and frame state.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            running_check_reg <= 16'h0000;
            inside_frame_reg  <= 1'b0;
        end else if (st_fire) begin
            running_check_reg <= acc_updated;
            inside_frame_reg  <= !st_end_reg;
        end
    end

    // Result register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (st_fire && st_end_reg) begin
            out_valid_reg <= 1'b1;
        end else if (m_ready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (st_fire && st_end_reg) begin
            out_value_reg <= result;
        end
    end

    assign m_valid          = out_valid_reg;
    assign m_checksum_value = out_value_reg;

    // A frame-end byte leaving the stage closes the frame and fills the result register.
    a_end_closes_frame: assert property (@(posedge aclk) disable iff (!aresetn)
        st_fire && st_end_reg |=> !inside_frame_reg && out_valid_reg)
        else $error("frame end did not close the frame or post a result");

    // A frame-end byte is never dropped while a result is stalled.
    a_end_held_on_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        st_valid_reg && st_end_reg && out_valid_reg && !m_ready |=> st_valid_reg && st_end_reg)
        else $error("frame-end byte lost while result stalled");

    // The input side stays open whenever no frame-end byte waits on the result register.
    a_no_needless_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !(st_valid_reg && st_end_reg) |-> s_ready)
        else $error("input stalled without a waiting frame-end byte");

endmodule
